FILE: hw/rtl/euv_pkg.sv
// euv_pkg: widths, reset values, register indexes and divider constants
// for the encoder unwrap and velocity block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package euv_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int TURN_BITS  = 32;
  localparam int POS_BITS   = TURN_BITS + ANGLE_BITS;
  localparam int SPEED_BITS = 33;
  localparam int TIME_BITS  = 32;

  localparam int THR_BITS   = 12;
  localparam int LIM_BITS   = 8;
  localparam int IVL_BITS   = 20;
  localparam int CFG_DATA_BITS = 20;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(3276);
  localparam logic [LIM_BITS-1:0] LIM_RESET = LIM_BITS'(10);
  localparam logic [IVL_BITS-1:0] MIN_IVL_RESET = IVL_BITS'(100);
  localparam logic [IVL_BITS-1:0] MAX_IVL_RESET = IVL_BITS'(500000);

  // counts per second = delta * 15625 * 64 / dt
  localparam int MUL_STEPS = 14;
  localparam logic [MUL_STEPS-1:0] MUL_K = MUL_STEPS'(15625);
  localparam int MUL_SHIFT = 6;
  localparam int ACC_BITS  = POS_BITS - 1 + MUL_STEPS;
  localparam int QUO_BITS  = 34;
  localparam int NUM_LO    = QUO_BITS - MUL_SHIFT;
  localparam int HI_BITS   = ACC_BITS - NUM_LO;
  localparam int CNT_BITS  = 6;
  localparam logic [QUO_BITS-1:0] SPEED_LIMIT = QUO_BITS'(64'd4096000000);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WRAP_THR  = 2'd0,
    CFG_ERR_LIMIT = 2'd1,
    CFG_MIN_IVL   = 2'd2,
    CFG_MAX_IVL   = 2'd3
  } cfg_idx_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_EVAL = 9'b000000010,
    S_DIFF = 9'b000000100,
    S_MAG  = 9'b000001000,
    S_MUL  = 9'b000010000,
    S_CHK  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/euv_if.sv
// euv_if: input and result word channels (valid, ready, payload)
// depends on euv_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface euv_in_if
  import euv_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  read_ok;
  logic [ANGLE_BITS-1:0] raw_angle;
  logic [TIME_BITS-1:0]  time_us;

  modport source (output valid, read_ok, raw_angle, time_us, input ready);
  modport sink   (input valid, read_ok, raw_angle, time_us, output ready);
endinterface

interface euv_out_if
  import euv_pkg::*;
;
  logic                         valid;
  logic                         ready;
  logic                         sample_valid;
  logic [ANGLE_BITS-1:0]        single_angle;
  logic signed [POS_BITS-1:0]   multi_position;
  logic signed [SPEED_BITS-1:0] speed;
  logic                         recover_request;
  logic                         sensor_ready;

  modport source (output valid, sample_valid, single_angle, multi_position, speed,
                  recover_request, sensor_ready, input ready);
  modport sink   (input valid, sample_valid, single_angle, multi_position, speed,
                  recover_request, sensor_ready, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/encoder_unwrap_velocity.sv
// encoder_unwrap_velocity: multi-turn unwrap and serial velocity estimate
// depends on euv_pkg and the euv_in_if / euv_out_if channels
`timescale 1ns / 1ps
`default_nettype none

// One read word in, one result word out. A failed read or the first good
// read after reset goes from S_EVAL straight to S_DONE. A good read with a
// velocity update scales the position delta by a 14-step shift-add
// multiplier (one constant bit per cycle) and then divides it by the clamped
// interval in a 34-step restoring divider that retires one quotient bit per
// cycle; a result that would saturate skips the divider and goes straight to
// S_FIN. The finished result sits in an output register, so the next word is
// taken while it waits for the sink.
module encoder_unwrap_velocity
  import euv_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire cfg_idx_t                 cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  euv_in_if.sink                        in_if,
  euv_out_if.source                     out_if
);

  state_t state_r;

  logic [THR_BITS-1:0] thr_r;
  logic [LIM_BITS-1:0] lim_r;
  logic [IVL_BITS-1:0] min_r;
  logic [IVL_BITS-1:0] max_r;

  logic                  ok_r;
  logic [ANGLE_BITS-1:0] raw_r;
  logic [TIME_BITS-1:0]  time_r;

  logic [ANGLE_BITS-1:0] prev_r;
  logic [TURN_BITS-1:0]  turn_r;
  logic [TIME_BITS-1:0]  last_time_r;
  logic [POS_BITS-1:0]   last_pos_r;
  logic                  primed_r;
  logic [SPEED_BITS-1:0] speed_r;
  logic [LIM_BITS-1:0]   fail_r;
  logic                  ready_r;
  logic                  recover_r;

  logic [POS_BITS-1:0]  pos_r;
  logic [POS_BITS-1:0]  delta_r;
  logic                 neg_r;
  logic [POS_BITS-1:0]  dmag_r;
  logic [IVL_BITS-1:0]  dt_r;
  logic [MUL_STEPS-1:0] k_r;
  logic [ACC_BITS-1:0]  acc_r;
  logic [IVL_BITS-1:0]  rem_r;
  logic [QUO_BITS-1:0]  num_r;
  logic [QUO_BITS-1:0]  quo_r;
  logic [CNT_BITS-1:0]  cnt_r;

  logic                         out_valid_r;
  logic                         out_sample_r;
  logic [ANGLE_BITS-1:0]        out_angle_r;
  logic [POS_BITS-1:0]          out_pos_r;
  logic [SPEED_BITS-1:0]        out_speed_r;
  logic                         out_recover_r;
  logic                         out_ready_flag_r;

  logic in_fire;
  logic out_load;

  // unwrap
  logic                  up;
  logic [ANGLE_BITS-1:0] mag;
  logic [TURN_BITS-1:0]  turn_nxt;
  logic [POS_BITS-1:0]   pos_new;
  logic [LIM_BITS-1:0]   fail_inc;

  // interval clamp
  logic [TIME_BITS-1:0]  dt_raw;
  logic [TIME_BITS-1:0]  dt_lo;
  logic [TIME_BITS-1:0]  dt_hi;
  logic [IVL_BITS-1:0]   dt_clamp;
  logic [POS_BITS-1:0]   delta_new;

  // serial multiply and divide
  logic [ACC_BITS-1:0]   acc_nxt;
  logic [HI_BITS-1:0]    acc_hi;
  logic [IVL_BITS:0]     rem_sh;
  logic                  rem_ge;
  logic [IVL_BITS-1:0]   rem_nxt;
  logic [QUO_BITS-1:0]   quo_sat;
  logic [QUO_BITS-1:0]   quo_neg;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_if.ready);

  assign in_if.ready           = (state_r == S_IDLE);
  assign out_if.valid          = out_valid_r;
  assign out_if.sample_valid   = out_sample_r;
  assign out_if.single_angle   = out_angle_r;
  assign out_if.multi_position = out_pos_r;
  assign out_if.speed          = out_speed_r;
  assign out_if.recover_request = out_recover_r;
  assign out_if.sensor_ready   = out_ready_flag_r;

  always_comb begin
    up       = raw_r > prev_r;
    mag      = up ? (raw_r - prev_r) : (prev_r - raw_r);
    turn_nxt = turn_r;
    if (mag > thr_r) begin
      turn_nxt = up ? (turn_r - TURN_BITS'(1)) : (turn_r + TURN_BITS'(1));
    end
    pos_new  = {turn_nxt, raw_r};
    fail_inc = fail_r + LIM_BITS'(1);

    dt_raw    = time_r - last_time_r;
    dt_lo     = (dt_raw < TIME_BITS'(min_r)) ? TIME_BITS'(min_r) : dt_raw;
    dt_hi     = (dt_lo > TIME_BITS'(max_r)) ? TIME_BITS'(max_r) : dt_lo;
    dt_clamp  = (dt_hi == '0) ? IVL_BITS'(1) : dt_hi[IVL_BITS-1:0];
    delta_new = pos_r - last_pos_r;

    acc_nxt = {acc_r[ACC_BITS-2:0], 1'b0}
            + (k_r[MUL_STEPS-1] ? ACC_BITS'(dmag_r) : ACC_BITS'(0));
    acc_hi  = acc_r[ACC_BITS-1:NUM_LO];

    rem_sh  = {rem_r, num_r[QUO_BITS-1]};
    rem_ge  = rem_sh >= {1'b0, dt_r};
    rem_nxt = rem_ge ? IVL_BITS'(rem_sh - {1'b0, dt_r}) : rem_sh[IVL_BITS-1:0];

    quo_sat = (quo_r > SPEED_LIMIT) ? SPEED_LIMIT : quo_r;
    quo_neg = -quo_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      lim_r <= LIM_RESET;
      min_r <= MIN_IVL_RESET;
      max_r <= MAX_IVL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WRAP_THR:  thr_r <= cfg_data[THR_BITS-1:0];
        CFG_ERR_LIMIT: lim_r <= cfg_data[LIM_BITS-1:0];
        CFG_MIN_IVL:   min_r <= cfg_data[IVL_BITS-1:0];
        CFG_MAX_IVL:   max_r <= cfg_data[IVL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      turn_r      <= '0;
      last_time_r <= '0;
      last_pos_r  <= '0;
      primed_r    <= 1'b0;
      speed_r     <= '0;
      fail_r      <= '0;
      ready_r     <= 1'b0;
      recover_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            ok_r    <= in_if.read_ok;
            raw_r   <= in_if.raw_angle;
            time_r  <= in_if.time_us;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!ok_r) begin
            if (fail_inc >= lim_r) begin
              recover_r <= 1'b1;
              fail_r    <= '0;
            end else begin
              recover_r <= 1'b0;
              fail_r    <= fail_inc;
            end
            state_r <= S_DONE;
          end else begin
            recover_r <= 1'b0;
            fail_r    <= '0;
            prev_r    <= raw_r;
            turn_r    <= turn_nxt;
            pos_r     <= pos_new;
            ready_r   <= 1'b1;
            if (!primed_r) begin
              primed_r    <= 1'b1;
              speed_r     <= '0;
              last_pos_r  <= pos_new;
              last_time_r <= time_r;
              state_r     <= S_DONE;
            end else begin
              state_r <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          delta_r     <= delta_new;
          neg_r       <= delta_new[POS_BITS-1];
          dt_r        <= dt_clamp;
          last_pos_r  <= pos_r;
          last_time_r <= time_r;
          state_r     <= S_MAG;
        end
        S_MAG: begin
          dmag_r  <= neg_r ? -delta_r : delta_r;
          k_r     <= MUL_K;
          acc_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          acc_r <= acc_nxt;
          k_r   <= {k_r[MUL_STEPS-2:0], 1'b0};
          cnt_r <= cnt_r + CNT_BITS'(1);
          if (cnt_r == CNT_BITS'(MUL_STEPS - 1)) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          cnt_r <= '0;
          if (acc_hi >= HI_BITS'(dt_r)) begin
            quo_r   <= SPEED_LIMIT;
            state_r <= S_FIN;
          end else begin
            rem_r   <= acc_hi[IVL_BITS-1:0];
            num_r   <= {acc_r[NUM_LO-1:0], {MUL_SHIFT{1'b0}}};
            quo_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          num_r <= {num_r[QUO_BITS-2:0], 1'b0};
          quo_r <= {quo_r[QUO_BITS-2:0], rem_ge};
          cnt_r <= cnt_r + CNT_BITS'(1);
          if (cnt_r == CNT_BITS'(QUO_BITS - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          speed_r <= neg_r ? quo_neg[SPEED_BITS-1:0] : quo_sat[SPEED_BITS-1:0];
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r     <= ok_r;
      out_angle_r      <= prev_r;
      out_pos_r        <= last_pos_r;
      out_speed_r      <= speed_r;
      out_recover_r    <= recover_r;
      out_ready_flag_r <= ready_r;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_if.ready)
    else $error("input taken while a word is in flight");

  a_rem_below_dt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < dt_r))
    else $error("divider remainder not below interval");

  a_dt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (dt_r != '0))
    else $error("zero interval reached the divider");

  a_recover_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_recover_r) |-> !out_sample_r)
    else $error("recovery request on a good sample");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/encoder_unwrap_velocity_tb.sv
// encoder_unwrap_velocity_tb: self-checking bench for the encoder unwrap and
// velocity block, with directed words, random traffic, random idling and a stall watchdog
// depends on euv_pkg, the euv_in_if / euv_out_if channels and encoder_unwrap_velocity
`timescale 1ns / 1ps

module encoder_unwrap_velocity_tb
  import euv_pkg::*;
;

  localparam int IDLE_PCT = 11;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int REPORT_CAP = 30;
  localparam logic [63:0] US_PER_SEC = 64'd1000000;
  localparam logic [63:0] SPEED_CAP = 64'd4096000000;

  typedef struct packed {
    logic                  sample_valid;
    logic [ANGLE_BITS-1:0] single_angle;
    logic [POS_BITS-1:0]   multi_position;
    logic [SPEED_BITS-1:0] speed;
    logic                  recover_request;
    logic                  sensor_ready;
  } readout_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  cfg_idx_t                 cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  euv_in_if  in_ch();
  euv_out_if out_ch();

  encoder_unwrap_velocity u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  // tracker settings and state
  logic [THR_BITS-1:0]   wrap_thr  = THR_RESET;
  logic [LIM_BITS-1:0]   err_limit = LIM_RESET;
  logic [IVL_BITS-1:0]   min_ivl   = MIN_IVL_RESET;
  logic [IVL_BITS-1:0]   max_ivl   = MAX_IVL_RESET;
  logic [ANGLE_BITS-1:0] prev_angle = '0;
  logic [TURN_BITS-1:0]  turns      = '0;
  logic [TIME_BITS-1:0]  held_time  = '0;
  logic [POS_BITS-1:0]   held_pos   = '0;
  logic                  primed     = 1'b0;
  logic [SPEED_BITS-1:0] held_speed = '0;
  logic [LIM_BITS-1:0]   fail_cnt   = '0;
  logic                  seen_good  = 1'b0;

  readout_t pending_readouts[$];
  int       error_count = 0;
  int       stall_cycles = 0;
  bit       no_idle = 1'b0;

  // stimulus trajectory
  logic [ANGLE_BITS-1:0] ang_now = '0;
  logic [TIME_BITS-1:0]  t_now = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic readout_t unwrap_step(input logic ok,
                                           input logic [ANGLE_BITS-1:0] raw,
                                           input logic [TIME_BITS-1:0] now);
    readout_t              r;
    logic                  up;
    logic [ANGLE_BITS-1:0] mag;
    logic [POS_BITS-1:0]   pos;
    logic [POS_BITS-1:0]   delta;
    logic [POS_BITS-1:0]   dmag;
    logic [TIME_BITS-1:0]  dt;
    logic [63:0]           q;
    logic [SPEED_BITS-1:0] spd;
    r = '0;
    if (!ok) begin
      fail_cnt = fail_cnt + 1'b1;
      if (fail_cnt >= err_limit) begin
        r.recover_request = 1'b1;
        fail_cnt = '0;
      end
    end else begin
      r.sample_valid = 1'b1;
      fail_cnt = '0;
      up = raw > prev_angle;
      mag = up ? raw - prev_angle : prev_angle - raw;
      if (mag > wrap_thr) turns = up ? turns - 1'b1 : turns + 1'b1;
      prev_angle = raw;
      pos = {turns, raw};
      if (!primed) begin
        primed = 1'b1;
        held_speed = '0;
      end else begin
        dt = now - held_time;
        delta = pos - held_pos;
        dmag = delta[POS_BITS-1] ? -delta : delta;
        if (dt < TIME_BITS'(min_ivl)) dt = TIME_BITS'(min_ivl);
        if (dt > TIME_BITS'(max_ivl)) dt = TIME_BITS'(max_ivl);
        if (dt == '0) dt = TIME_BITS'(1);
        q = (64'(dmag) * US_PER_SEC) / 64'(dt);
        if (q > SPEED_CAP) q = SPEED_CAP;
        spd = q[SPEED_BITS-1:0];
        held_speed = delta[POS_BITS-1] ? -spd : spd;
      end
      held_time = now;
      held_pos = pos;
      seen_good = 1'b1;
    end
    r.single_angle = prev_angle;
    r.multi_position = held_pos;
    r.speed = held_speed;
    r.sensor_ready = seen_good;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input readout_t got, input readout_t want);
    error_count++;
    if (error_count <= REPORT_CAP)
      $display({"%0t %s: got v=%0b a=%0d p=%0d s=%0d r=%0b k=%0b",
                " want v=%0b a=%0d p=%0d s=%0d r=%0b k=%0b"},
               $time, what, got.sample_valid, got.single_angle, $signed(got.multi_position),
               $signed(got.speed), got.recover_request, got.sensor_ready,
               want.sample_valid, want.single_angle, $signed(want.multi_position),
               $signed(want.speed), want.recover_request, want.sensor_ready);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WRAP_THR:  wrap_thr = data[THR_BITS-1:0];
      CFG_ERR_LIMIT: err_limit = data[LIM_BITS-1:0];
      CFG_MIN_IVL:   min_ivl = data[IVL_BITS-1:0];
      CFG_MAX_IVL:   max_ivl = data[IVL_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_BITS-1:0] thr,
                            input logic [CFG_DATA_BITS-1:0] lim,
                            input logic [CFG_DATA_BITS-1:0] mn,
                            input logic [CFG_DATA_BITS-1:0] mx);
    write_reg(CFG_WRAP_THR, thr);
    write_reg(CFG_ERR_LIMIT, lim);
    write_reg(CFG_MIN_IVL, mn);
    write_reg(CFG_MAX_IVL, mx);
  endtask

  task automatic send_word(input logic ok, input logic [ANGLE_BITS-1:0] raw,
                           input logic [TIME_BITS-1:0] t);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.read_ok <= ok;
    in_ch.raw_angle <= raw;
    in_ch.time_us <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_readouts.push_back(unwrap_step(ok, raw, t));
  endtask

  task automatic send_good(input logic [ANGLE_BITS-1:0] raw, input logic [TIME_BITS-1:0] dt);
    ang_now = raw;
    t_now = t_now + dt;
    send_word(1'b1, raw, t_now);
  endtask

  task automatic send_fail();
    send_word(1'b0, ANGLE_BITS'($urandom), $urandom);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random_word(input int fail_pct);
    int pick;
    int step;
    pick = $urandom_range(0, 99);
    if (pick < fail_pct) begin
      send_fail();
    end else begin
      if (pick < fail_pct + 5) begin
        ang_now = ANGLE_BITS'($urandom);
        t_now = $urandom;
      end else begin
        case ($urandom_range(0, 4))
          0: step = int'($urandom_range(0, 40)) - 20;
          1: step = int'($urandom_range(0, 600)) - 300;
          2: step = int'($urandom_range(0, 8190)) - 4095;
          3: step = int'(wrap_thr) + int'($urandom_range(0, 4)) - 2;
          default: step = -int'(wrap_thr) + int'($urandom_range(0, 4)) - 2;
        endcase
        ang_now = ANGLE_BITS'(int'(ang_now) + step);
        case ($urandom_range(0, 3))
          0: t_now = t_now + $urandom_range(0, 300);
          1: t_now = t_now + $urandom_range(0, 20000);
          2: t_now = t_now + $urandom_range(0, 1200000);
          default: t_now = t_now + $urandom_range(0, 2);
        endcase
      end
      send_word(1'b1, ang_now, t_now);
    end
  endtask

  task automatic run_phase(input logic [CFG_DATA_BITS-1:0] thr,
                           input logic [CFG_DATA_BITS-1:0] lim,
                           input logic [CFG_DATA_BITS-1:0] mn,
                           input logic [CFG_DATA_BITS-1:0] mx,
                           input int count, input int fail_pct);
    set_config(thr, lim, mn, mx);
    ang_now = ANGLE_BITS'($urandom);
    t_now = $urandom;
    repeat (count) send_random_word(fail_pct);
    settle();
  endtask

  // failure before any good read, then the first good read and one velocity update
  task automatic test_first_sample();
    send_word(1'b0, '1, '1);
    t_now = 32'd1000;
    send_good(12'd0, 32'd0);
    send_good(12'd100, 32'd1000);
    settle();
  endtask

  // crossing zero both ways, and the difference right at and above the threshold
  task automatic test_turn_wrap();
    write_reg(CFG_WRAP_THR, 20'd2048);
    send_good(12'd4095, 32'd500);
    send_good(12'd0, 32'd500);
    send_good(12'd2048, 32'd500);
    send_good(12'd0, 32'd500);
    send_good(12'd2049, 32'd500);
    settle();
  endtask

  task automatic test_failure_recovery();
    write_reg(CFG_ERR_LIMIT, 20'd3);
    repeat (4) send_fail();
    send_good(12'd2000, 32'd800);
    repeat (3) send_fail();
    settle();
    write_reg(CFG_ERR_LIMIT, 20'd0);
    repeat (2) send_fail();
    settle();
  endtask

  // crossed bounds, zero interval, timestamp wrap
  task automatic test_interval_clamp();
    write_reg(CFG_MIN_IVL, 20'd5000);
    write_reg(CFG_MAX_IVL, 20'd1000);
    send_good(12'd2100, 32'd10);
    settle();
    write_reg(CFG_MIN_IVL, 20'd0);
    write_reg(CFG_MAX_IVL, 20'd0);
    send_good(12'd2150, 32'd0);
    settle();
    write_reg(CFG_MIN_IVL, 20'd1);
    write_reg(CFG_MAX_IVL, 20'hFFFFF);
    t_now = 32'hFFFF_FF00;
    send_good(12'd2000, 32'd0);
    send_good(12'd1900, 32'h200);
    settle();
  endtask

  task automatic test_streaming_defaults();
    no_idle = 1'b1;
    run_phase(20'(THR_RESET), 20'(LIM_RESET), 20'(MIN_IVL_RESET), 20'(MAX_IVL_RESET),
              120, 10);
    no_idle = 1'b0;
  endtask

  task automatic test_config_extremes();
    run_phase(20'd0, 20'd1, 20'd0, 20'hFFFFF, 60, 15);
    run_phase(20'd4095, 20'd255, 20'hFFFFF, 20'hFFFFF, 60, 10);
    run_phase(20'd2048, 20'd0, 20'd0, 20'd0, 60, 10);
    run_phase(20'd1500, 20'd2, 20'd5000, 20'd200, 60, 20);
  endtask

  task automatic test_long_error_burst();
    set_config(20'(THR_RESET), 20'd255, 20'(MIN_IVL_RESET), 20'(MAX_IVL_RESET));
    repeat (256) send_fail();
    send_good(ANGLE_BITS'($urandom), 32'd300);
    settle();
  endtask

  task automatic test_random_settings();
    repeat (3) run_phase(20'($urandom), 20'($urandom), 20'($urandom_range(0, 20000)),
                         20'($urandom), 60, 12);
  endtask

  // result checker and sink ready
  initial begin
    readout_t got;
    readout_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.sample_valid = out_ch.sample_valid;
        got.single_angle = out_ch.single_angle;
        got.multi_position = out_ch.multi_position;
        got.speed = out_ch.speed;
        got.recover_request = out_ch.recover_request;
        got.sensor_ready = out_ch.sensor_ready;
        if (pending_readouts.size() == 0) begin
          report_mismatch("unexpected word", got, '0);
        end else begin
          want = pending_readouts.pop_front();
          if (got !== want) report_mismatch("word mismatch", got, want);
        end
      end
      out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_WRAP_THR;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.read_ok <= 1'b0;
    in_ch.raw_angle <= '0;
    in_ch.time_us <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_sample();
    test_turn_wrap();
    test_failure_recovery();
    test_interval_clamp();
    test_streaming_defaults();
    test_config_extremes();
    test_long_error_burst();
    test_random_settings();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: encoder_unwrap_velocity.f
hw/rtl/euv_pkg.sv
hw/rtl/euv_if.sv
hw/rtl/encoder_unwrap_velocity.sv
tb/sv/encoder_unwrap_velocity_tb.sv
